### rtl/uwb_range_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range frame parser
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef UWB_RANGE_FRAME_PARSER_ASSERT_SVH
`define UWB_RANGE_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define URFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define URFP_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define URFP_ASSERT(label, clk, rst_n, prop, msg)
`define URFP_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

### rtl/urfp_pkg.sv
// ----------------------------------------------------------------------------
// urfp_pkg
// Shared constants and helpers for the range frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urfp_pkg;

    localparam int FRAME_LEN = 6;
    localparam int CNT_W     = 3;
    localparam int SLOT_W    = 2;
    localparam int IDX_W     = 3;

    localparam logic [7:0] MARKER_BYTE = 8'd254;
    localparam logic [7:0] TYPE_RANGE  = 8'd3;
    localparam logic [7:0] TYPE_X      = 8'd0;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_ANCHOR_A = 3'd0;
    localparam logic [IDX_W-1:0] REG_TAG_A    = 3'd3;

    typedef enum logic [2:0] {
        KIND_ACCEPT = 3'd0,
        KIND_REJECT = 3'd1,
        KIND_TAG_X  = 3'd2,
        KIND_TAG_Y  = 3'd3,
        KIND_NONE   = 3'd4
    } kind_t;

    // Fixed point with LSB 2^-149, covering magnitudes below 2^25.
    localparam int FIX_W = 174;
    localparam int DIF_W = FIX_W + 2;
    localparam logic [7:0] FIX_MAX_EXP = 8'd151;
    localparam logic [7:0] EXP_SPECIAL = 8'hFF;

    // A float difference rounds below 2.0 iff the exact one is below 2 - 2^-24.
    localparam logic [DIF_W-1:0] NEAR_LIM =
        (DIF_W'(1) << 150) - (DIF_W'(1) << 125);

    function automatic logic [FIX_W-1:0] to_fix(input logic [31:0] v);
        logic [23:0] mant;
        logic [7:0]  sh;
        mant = {(v[30:23] != 8'd0), v[22:0]};
        sh   = (v[30:23] == 8'd0) ? 8'd0 : (v[30:23] - 8'd1);
        return {{(FIX_W-24){1'b0}}, mant} << sh;
    endfunction

endpackage

### rtl/urfp_if.sv
// ----------------------------------------------------------------------------
// urfp_if
// Valid/ready channels of the range frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface urfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface urfp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [1:0]  slot;
    logic [7:0]  sender;
    logic [31:0] stored_value;
    modport source (output valid, output kind, output slot, output sender,
                    output stored_value, input ready);
    modport sink   (input valid, input kind, input slot, input sender,
                    input stored_value, output ready);
endinterface

interface urfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/uwb_range_frame_parser.sv
// A frame's result is registered in stage 1, then stage 2, then the output register.
// One byte per cycle unless stalled; a frame of seven bytes yields at most one result.
// The float compare path (align, then a wide subtract) is split over two register stages.
// Output is a register: bytes keep flowing while a result waits unless both stages are full.
// Reset (rst_n low, async) clears framing, all stored distances and positions,
// and loads slot ids 0,1,2 (anchors) and 0,1 (tags).
// ----------------------------------------------------------------------------
// uwb_range_frame_parser
// Parses marker-led serial frames and updates anchor ranges and tag positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uwb_range_frame_parser_assert.svh"

module uwb_range_frame_parser #(
    parameter int NUM_ANCHORS = 3,
    parameter int NUM_TAGS    = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    urfp_byte_if.sink   rx,
    urfp_res_if.source  res,
    urfp_cfg_if.sink    cfg
);
    import urfp_pkg::*;

    // ------------------------------------------------------------------
    // Configuration: slot ids, always writable
    // ------------------------------------------------------------------
    logic [7:0] anchor_id_reg [NUM_ANCHORS];
    logic [7:0] tag_id_reg    [NUM_TAGS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ANCHORS; i++)
                anchor_id_reg[i] <= 8'(i);
            for (int i = 0; i < NUM_TAGS; i++)
                tag_id_reg[i] <= 8'(i);
        end
        else if (cfg.valid)
        begin
            for (int i = 0; i < NUM_ANCHORS; i++)
                if (cfg.index == REG_ANCHOR_A + IDX_W'(i))
                    anchor_id_reg[i] <= cfg.data;
            for (int i = 0; i < NUM_TAGS; i++)
                if (cfg.index == REG_TAG_A + IDX_W'(i))
                    tag_id_reg[i] <= cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic p1_valid_reg, p2_valid_reg, out_valid_reg;
    logic out_ok, p2_adv, p1_adv, rx_beat;

    assign out_ok  = !out_valid_reg || res.ready;
    assign p2_adv  = p2_valid_reg && out_ok;
    // Stage 1 only moves into an empty stage 2, so the distance it reads
    // already holds the update of the frame ahead of it.
    assign p1_adv  = p1_valid_reg && !p2_valid_reg;
    assign rx.ready = !p1_valid_reg || p1_adv;
    assign rx_beat = rx.valid && rx.ready;

    // ------------------------------------------------------------------
    // Framing: marker opens a frame, six data bytes follow
    // ------------------------------------------------------------------
    logic             in_frame_reg;
    logic [CNT_W-1:0] byte_count_reg;
    logic [7:0]       fb_reg [FRAME_LEN-1];
    logic             frame_done;

    assign frame_done = rx_beat && in_frame_reg
                     && (byte_count_reg == CNT_W'(FRAME_LEN - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            byte_count_reg <= '0;
        end
        else if (rx_beat)
        begin
            if (in_frame_reg)
            begin
                byte_count_reg <= byte_count_reg + CNT_W'(1);
                if (frame_done)
                    in_frame_reg <= 1'b0;
            end
            // Marker restarts a frame even if it just closed one
            if (rx.rx_byte == MARKER_BYTE)
            begin
                byte_count_reg <= '0;
                in_frame_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_beat && in_frame_reg)
            for (int i = 0; i < FRAME_LEN - 1; i++)
                if (byte_count_reg == CNT_W'(i))
                    fb_reg[i] <= rx.rx_byte;
    end

    // ------------------------------------------------------------------
    // Stage 1: captured frame
    // ------------------------------------------------------------------
    logic [7:0]  p1_sender_reg, p1_type_reg;
    logic [31:0] p1_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (rx.ready)
            p1_valid_reg <= frame_done;
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            p1_sender_reg <= fb_reg[0];
            p1_type_reg   <= fb_reg[1];
            p1_value_reg  <= {rx.rx_byte, fb_reg[4], fb_reg[3], fb_reg[2]};
        end
    end

    // Slot lookup (lowest matching slot wins) and float alignment
    logic [31:0] anchor_dist_reg [NUM_ANCHORS];
    logic [31:0] tag_x_reg       [NUM_TAGS];
    logic [31:0] tag_y_reg       [NUM_TAGS];

    logic              s1_range, s1_hit;
    logic [SLOT_W-1:0] s1_slot;
    logic [31:0]       s1_old;

    always_comb
    begin
        s1_range = (p1_type_reg == TYPE_RANGE);
        s1_hit   = 1'b0;
        s1_slot  = '0;
        s1_old   = '0;
        if (s1_range)
        begin
            for (int i = NUM_ANCHORS - 1; i >= 0; i--)
                if (anchor_id_reg[i] == p1_sender_reg)
                begin
                    s1_hit  = 1'b1;
                    s1_slot = SLOT_W'(i);
                    s1_old  = anchor_dist_reg[i];
                end
        end
        else
        begin
            for (int i = NUM_TAGS - 1; i >= 0; i--)
                if (tag_id_reg[i] == p1_sender_reg)
                begin
                    s1_hit  = 1'b1;
                    s1_slot = SLOT_W'(i);
                end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: aligned operands
    // ------------------------------------------------------------------
    logic              p2_range_reg, p2_hit_reg, p2_is_x_reg;
    logic [SLOT_W-1:0] p2_slot_reg;
    logic [7:0]        p2_sender_reg;
    logic [31:0]       p2_value_reg, p2_old_reg;
    logic [FIX_W-1:0]  p2_fix_old_reg, p2_fix_new_reg;
    logic              p2_old_zero_reg, p2_finite_reg, p2_in_range_reg, p2_same_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (p1_adv)
            p2_valid_reg <= 1'b1;
        else if (p2_adv)
            p2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (p1_adv)
        begin
            p2_range_reg    <= s1_range;
            p2_hit_reg      <= s1_hit;
            p2_is_x_reg     <= (p1_type_reg == TYPE_X);
            p2_slot_reg     <= s1_slot;
            p2_sender_reg   <= p1_sender_reg;
            p2_value_reg    <= p1_value_reg;
            p2_old_reg      <= s1_old;
            p2_fix_old_reg  <= to_fix(s1_old);
            p2_fix_new_reg  <= to_fix(p1_value_reg);
            p2_old_zero_reg <= (s1_old[30:0] == 31'd0);
            p2_finite_reg   <= (s1_old[30:23] != EXP_SPECIAL)
                            && (p1_value_reg[30:23] != EXP_SPECIAL);
            p2_in_range_reg <= (s1_old[30:23] <= FIX_MAX_EXP)
                            && (p1_value_reg[30:23] <= FIX_MAX_EXP);
            p2_same_reg     <= (s1_old == p1_value_reg);
        end
    end

    // Exact distance of the two values; outside the fixed range only equal values are close.
    // Same signs subtract magnitudes (both orders in parallel), opposite signs add them.
    logic [DIF_W-1:0] s2_a, s2_b, s2_fwd, s2_rev, s2_sum, s2_abs;
    logic             s2_near, s2_accept;
    kind_t            s2_kind;
    logic [31:0]      s2_stored;
    logic [SLOT_W-1:0] s2_slot;

    always_comb
    begin
        s2_a   = {2'b00, p2_fix_old_reg};
        s2_b   = {2'b00, p2_fix_new_reg};
        s2_fwd = s2_a - s2_b;
        s2_rev = s2_b - s2_a;
        s2_sum = s2_a + s2_b;
        if (p2_old_reg[31] != p2_value_reg[31])
            s2_abs = s2_sum;
        else
            s2_abs = s2_fwd[DIF_W-1] ? s2_rev : s2_fwd;
        s2_near = p2_in_range_reg ? (s2_abs < NEAR_LIM) : p2_same_reg;
        s2_accept = p2_old_zero_reg || (p2_finite_reg && s2_near);

        s2_kind   = KIND_NONE;
        s2_stored = '0;
        s2_slot   = '0;
        if (p2_hit_reg)
        begin
            s2_slot = p2_slot_reg;
            if (p2_range_reg)
            begin
                s2_kind   = s2_accept ? KIND_ACCEPT : KIND_REJECT;
                s2_stored = s2_accept ? p2_value_reg : p2_old_reg;
            end
            else
            begin
                s2_kind   = p2_is_x_reg ? KIND_TAG_X : KIND_TAG_Y;
                s2_stored = p2_value_reg;
            end
        end
    end

    // Slot state update, once per frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ANCHORS; i++)
                anchor_dist_reg[i] <= '0;
            for (int i = 0; i < NUM_TAGS; i++)
            begin
                tag_x_reg[i] <= '0;
                tag_y_reg[i] <= '0;
            end
        end
        else if (p2_adv && p2_hit_reg)
        begin
            for (int i = 0; i < NUM_ANCHORS; i++)
                if (p2_range_reg && s2_accept && p2_slot_reg == SLOT_W'(i))
                    anchor_dist_reg[i] <= p2_value_reg;
            for (int i = 0; i < NUM_TAGS; i++)
                if (!p2_range_reg && p2_slot_reg == SLOT_W'(i))
                begin
                    if (p2_is_x_reg)
                        tag_x_reg[i] <= p2_value_reg;
                    else
                        tag_y_reg[i] <= p2_value_reg;
                end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    kind_t             out_kind_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [7:0]        out_sender_reg;
    logic [31:0]       out_stored_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (p2_adv)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (p2_adv)
        begin
            out_kind_reg   <= s2_kind;
            out_slot_reg   <= s2_slot;
            out_sender_reg <= p2_sender_reg;
            out_stored_reg <= s2_stored;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_kind_reg;
    assign res.slot         = out_slot_reg;
    assign res.sender       = out_sender_reg;
    assign res.stored_value = out_stored_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `URFP_NEVER(a_count_range, clk, rst_n, in_frame_reg && byte_count_reg >= CNT_W'(FRAME_LEN), "frame byte count overran")
    `URFP_ASSERT(a_none_zero, clk, rst_n, (out_valid_reg && out_kind_reg == KIND_NONE) |-> (out_slot_reg == '0 && out_stored_reg == '0), "unmatched result carries slot data")
    `URFP_ASSERT(a_anchor_slot, clk, rst_n, (out_valid_reg && (out_kind_reg == KIND_ACCEPT || out_kind_reg == KIND_REJECT)) |-> (32'(out_slot_reg) < 32'(NUM_ANCHORS)), "anchor slot out of range")
    `URFP_ASSERT(a_out_source, clk, rst_n, $rose(out_valid_reg) |-> $past(p2_valid_reg), "result without a processed frame")

endmodule
